[rtl/bipartite_check_with_undo_core_macros.svh]
// Assertion macros shared by the RTL.
`ifndef BIPARTITE_CHECK_WITH_UNDO_CORE_MACROS_SVH
`define BIPARTITE_CHECK_WITH_UNDO_CORE_MACROS_SVH
// Implication checked every clock, skipped during reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication, skipped during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[rtl/bcu_pkg.sv]
// ----------------------------------------------------------------------------
// bcu_pkg
// Types and constants for the bipartite check core with undo.
// ----------------------------------------------------------------------------
`default_nettype none
package bcu_pkg;
   localparam int MAX_VERTICES = 1024;
   localparam int MAX_OPS      = 4096;
   localparam int NODE_COUNT   = 2 * MAX_VERTICES;
   localparam int RB_DEPTH     = 2 * MAX_OPS;
   localparam int NODE_W       = $clog2(NODE_COUNT);
   localparam int SIZE_W       = NODE_W + 1;
   localparam int RB_W         = $clog2(RB_DEPTH);
   localparam int HIST_W       = $clog2(MAX_OPS);
   localparam int VTX_W        = 11;
   localparam int RB_ENTRY_W   = 1 + 2 * NODE_W;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_UNDO = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDO_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic             cmd;
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic       bipartite;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic              made;
      logic [NODE_W-1:0] root;
      logic [NODE_W-1:0] child;
   } rb_entry_type;
endpackage
`default_nettype wire

[rtl/bcu_ram.sv]
// ----------------------------------------------------------------------------
// bcu_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bcu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[rtl/bipartite_check_with_undo_core.sv]
// ----------------------------------------------------------------------------
// bipartite_check_with_undo_core
// Online bipartiteness check over a union-find store with stack-order undo.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: pulse start with req_data while busy is low; the
//   transaction is taken at that edge and busy rises on the next cycle.
//   cmd ADD adds edge (vertex_a, vertex_b); cmd UNDO pops the last add.
//   rsp_ channel: rsp_valid is high for one cycle with rsp_data (verdict and
//   status). The receiver cannot stall; results are never held off.
//   csr_ port: csr_we writes vertex_count; write only while idle.
// Sequencing: one shared sequencer drives the RAMs and walks parent links
//   node by node (address, read, compare); a walk covers at most 11 links.
//   Add: four finds, two more finds for the second union, then the size
//   updates and stack pushes. Add that closes an odd cycle: the four finds,
//   then the history write. Add on a graph already non-bipartite: the
//   history write only. Undo of a clean add: two stack pops, then the
//   history read. Undo of a marked add: the history read only. Error
//   results touch no table. busy drops with rsp_valid, and a start seen
//   in that cycle is taken; one transaction is in flight at a time.
// Reset: a clearing pass rewrites all 2048 entries of the parent and size
//   tables; busy stays high during it. Stack pointers clear at once.
`default_nettype none
module bipartite_check_with_undo_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire bcu_pkg::req_type req_data,
   output logic                 rsp_valid,
   output bcu_pkg::rsp_type     rsp_data,
   input  wire logic            csr_we,
   input  wire logic [10:0]     csr_vertex_count
);
   import bcu_pkg::*;
`include "bipartite_check_with_undo_core_macros.svh"

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DECIDE,
      S_FIND_RD, S_FIND_WT, S_FIND_CHK,
      S_JOIN_SZX, S_JOIN_SZX_WT, S_JOIN_SZY, S_JOIN_SZY_WT, S_JOIN_WR1,
      S_JOIN_WR2, S_PUSH,
      S_POP_RD, S_POP_WT, S_POP_SZR, S_POP_SZR_WT, S_POP_SZC, S_POP_SZC_WT,
      S_POP_WR1, S_POP_WR2,
      S_HIST_RD, S_HIST_WT, S_HIST_WR, S_DONE
   } state_type;

   state_type state_ff;
   logic [10:0]       vcount_ff;
   logic [NODE_W:0]   clr_ff;
   logic [NODE_W-1:0] node_ff;     // current node in a root walk
   logic [3:0]        walk_ff;     // which of six finds (0..3 check, 4..5 joins)
   logic [NODE_W-1:0] root_ff [4]; // roots of a0,b0,a1,b1
   logic [NODE_W-1:0] jx_ff, jy_ff;
   logic [SIZE_W-1:0] szx_ff, szy_ff;
   logic              join2_ff;    // second join / second pop
   logic [RB_W:0]     rb_top_ff;
   logic [HIST_W:0]   h_top_ff;
   logic              cur_bad_ff;  // history_bad[top-1], cached
   logic              bad_ff;
   rb_entry_type      ent_ff;
   req_type           req_ff;
   logic [1:0]        status_ff;

   // parent RAM
   logic              p_we;
   logic [NODE_W-1:0] p_addr, p_wd, p_rd;
   // size RAM
   logic              s_we;
   logic [NODE_W-1:0] s_addr;
   logic [SIZE_W-1:0] s_wd, s_rd;
   // rollback stack RAM
   logic              r_we;
   logic [RB_W-1:0]   r_addr;
   rb_entry_type      r_wd, r_rd;
   // history RAM
   logic              h_we;
   logic [HIST_W-1:0] h_addr;
   logic              h_wd, h_rd;

   bcu_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_parent (
      .clock, .wr_en(p_we), .addr(p_addr), .wr_data(p_wd), .rd_data(p_rd));
   bcu_ram #(.WIDTH(SIZE_W), .DEPTH(NODE_COUNT)) u_size (
      .clock, .wr_en(s_we), .addr(s_addr), .wr_data(s_wd), .rd_data(s_rd));
   bcu_ram #(.WIDTH(RB_ENTRY_W), .DEPTH(RB_DEPTH)) u_stack (
      .clock, .wr_en(r_we), .addr(r_addr), .wr_data(r_wd), .rd_data(r_rd));
   bcu_ram #(.WIDTH(1), .DEPTH(MAX_OPS)) u_hist (
      .clock, .wr_en(h_we), .addr(h_addr), .wr_data(h_wd), .rd_data(h_rd));

   // endpoint nodes
   logic [NODE_W-1:0] a0, b0;
   logic [10:0]       limit;
   logic              range_bad;
   assign a0 = NODE_W'({req_ff.vertex_a - 11'd1, 1'b0});
   assign b0 = NODE_W'({req_ff.vertex_b - 11'd1, 1'b0});
   assign limit = (vcount_ff < 11'(MAX_VERTICES)) ? vcount_ff : 11'(MAX_VERTICES);
   assign range_bad = (req_ff.vertex_a == '0) || (req_ff.vertex_b == '0) ||
                      (req_ff.vertex_a > limit) || (req_ff.vertex_b > limit);

   // start node of the next check walk (a0 -> b0 -> a1 -> b1)
   logic [NODE_W-1:0] walk_start;
   always_comb begin
      unique case (walk_ff[1:0])
         2'd0: walk_start = b0;
         2'd1: walk_start = a0 | NODE_W'(1);
         2'd2: walk_start = b0 | NODE_W'(1);
         2'd3: walk_start = a0;
      endcase
   end

   // memory port control
   always_comb begin
      p_we = 1'b0; p_addr = node_ff; p_wd = '0;
      s_we = 1'b0; s_addr = '0; s_wd = '0;
      r_we = 1'b0; r_addr = rb_top_ff[RB_W-1:0]; r_wd = '0;
      h_we = 1'b0; h_addr = '0; h_wd = bad_ff;
      unique case (state_ff)
         S_CLEAR: begin
            p_we = 1'b1; p_addr = clr_ff[NODE_W-1:0]; p_wd = clr_ff[NODE_W-1:0];
            s_we = 1'b1; s_addr = clr_ff[NODE_W-1:0]; s_wd = SIZE_W'(1);
         end
         S_JOIN_SZX, S_JOIN_SZX_WT: s_addr = jx_ff;
         S_JOIN_SZY, S_JOIN_SZY_WT: s_addr = jy_ff;
         S_JOIN_WR1: begin
            // smaller root points to the larger; on a tie x points to y
            p_we = 1'b1;
            s_we = 1'b1;
            if (szx_ff > szy_ff) begin
               p_addr = jy_ff; p_wd = jx_ff; s_addr = jx_ff;
            end else begin
               p_addr = jx_ff; p_wd = jy_ff; s_addr = jy_ff;
            end
            s_wd = szx_ff + szy_ff;
         end
         S_PUSH: begin
            r_we = 1'b1;
            r_wd.made  = (jx_ff != jy_ff);
            r_wd.root  = (szx_ff > szy_ff) ? jx_ff : jy_ff;
            r_wd.child = (szx_ff > szy_ff) ? jy_ff : jx_ff;
            if (jx_ff == jy_ff) begin
               r_wd.root = '0; r_wd.child = '0;
            end
         end
         S_POP_RD, S_POP_WT: r_addr = RB_W'(rb_top_ff - 1'b1);
         S_POP_SZR, S_POP_SZR_WT: s_addr = ent_ff.root;
         S_POP_SZC, S_POP_SZC_WT: s_addr = ent_ff.child;
         S_POP_WR1: begin
            s_we = ent_ff.made; s_addr = ent_ff.root; s_wd = szx_ff - szy_ff;
            p_we = ent_ff.made; p_addr = ent_ff.child; p_wd = ent_ff.child;
         end
         // h_top already decremented: the new top entry sits at h_top-1
         S_HIST_RD, S_HIST_WT: h_addr = HIST_W'(h_top_ff - 1'b1);
         S_HIST_WR: begin
            h_we = 1'b1; h_addr = h_top_ff[HIST_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         vcount_ff  <= 11'd1024;
         rb_top_ff  <= '0;
         h_top_ff   <= '0;
         cur_bad_ff <= 1'b0;
         rsp_valid  <= 1'b0;
         busy       <= 1'b1;
      end else begin
         rsp_valid <= (state_ff == S_DONE);
         if (csr_we) begin
            vcount_ff <= csr_vertex_count;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (NODE_W+1)'(NODE_COUNT - 1)) begin
                  state_ff <= S_IDLE;
                  busy     <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  busy     <= 1'b1;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               walk_ff   <= '0;
               join2_ff  <= 1'b0;
               if (req_ff.cmd == CMD_UNDO) begin
                  if (h_top_ff == '0) begin
                     status_ff <= ST_UNDO_EMPTY;
                     state_ff  <= S_DONE;
                  end else if (!cur_bad_ff) begin
                     status_ff <= ST_OK;
                     state_ff  <= S_POP_RD;
                  end else begin
                     status_ff <= ST_OK;
                     h_top_ff  <= h_top_ff - 1'b1;
                     state_ff  <= S_HIST_RD;
                  end
               end else if (range_bad) begin
                  status_ff <= ST_RANGE;
                  state_ff  <= S_DONE;
               end else if (h_top_ff >= (HIST_W+1)'(MAX_OPS)) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else if (h_top_ff != '0 && cur_bad_ff) begin
                  status_ff <= ST_OK;
                  bad_ff    <= 1'b1;
                  state_ff  <= S_HIST_WR;
               end else begin
                  status_ff <= ST_OK;
                  node_ff   <= a0;
                  state_ff  <= S_FIND_RD;
               end
            end
            S_FIND_RD: state_ff <= S_FIND_WT;
            S_FIND_WT: state_ff <= S_FIND_CHK;
            S_FIND_CHK: begin
               if (p_rd != node_ff) begin
                  node_ff  <= p_rd;
                  state_ff <= S_FIND_RD;
               end else begin
                  root_ff[walk_ff[1:0]] <= node_ff;
                  if (walk_ff == 4'd3) begin
                     if (root_ff[0] == root_ff[1] || root_ff[2] == node_ff) begin
                        bad_ff   <= 1'b1;
                        state_ff <= S_HIST_WR;
                     end else begin
                        // join(a0,b1): roots known
                        jx_ff    <= root_ff[0];
                        jy_ff    <= node_ff;
                        state_ff <= S_JOIN_SZX;
                     end
                  end else if (walk_ff == 4'd4) begin
                     jx_ff    <= node_ff;
                     walk_ff  <= 4'd5;
                     node_ff  <= b0;
                     state_ff <= S_FIND_RD;
                  end else if (walk_ff == 4'd5) begin
                     jy_ff    <= node_ff;
                     state_ff <= S_JOIN_SZX;
                  end else begin
                     walk_ff  <= walk_ff + 1'b1;
                     node_ff  <= walk_start;
                     state_ff <= S_FIND_RD;
                  end
               end
            end
            S_JOIN_SZX:    state_ff <= S_JOIN_SZX_WT;
            S_JOIN_SZX_WT: begin
               szx_ff   <= s_rd;
               state_ff <= S_JOIN_SZY;
            end
            S_JOIN_SZY:    state_ff <= S_JOIN_SZY_WT;
            S_JOIN_SZY_WT: begin
               szy_ff   <= s_rd;
               state_ff <= (jx_ff == jy_ff) ? S_PUSH : S_JOIN_WR1;
            end
            S_JOIN_WR1: state_ff <= S_PUSH;
            S_PUSH: begin
               rb_top_ff <= rb_top_ff + 1'b1;
               if (!join2_ff) begin
                  // second join: a1 with b0, roots re-found after first union
                  join2_ff <= 1'b1;
                  walk_ff  <= 4'd4;
                  node_ff  <= a0 | NODE_W'(1);
                  state_ff <= S_FIND_RD;
               end else begin
                  bad_ff   <= 1'b0;
                  state_ff <= S_HIST_WR;
               end
            end
            S_POP_RD: state_ff <= S_POP_WT;
            S_POP_WT: begin
               ent_ff    <= r_rd;
               rb_top_ff <= rb_top_ff - 1'b1;
               state_ff  <= S_POP_SZR;
            end
            S_POP_SZR:    state_ff <= S_POP_SZR_WT;
            S_POP_SZR_WT: begin
               szx_ff   <= s_rd;
               state_ff <= S_POP_SZC;
            end
            S_POP_SZC:    state_ff <= S_POP_SZC_WT;
            S_POP_SZC_WT: begin
               szy_ff   <= s_rd;
               state_ff <= S_POP_WR1;
            end
            S_POP_WR1: state_ff <= S_POP_WR2;
            S_POP_WR2: begin
               if (!join2_ff) begin
                  join2_ff <= 1'b1;
                  state_ff <= S_POP_RD;
               end else begin
                  h_top_ff <= h_top_ff - 1'b1;
                  state_ff <= S_HIST_RD;
               end
            end
            S_HIST_RD: begin
               // h_top already decremented; refresh cached top flag
               if (h_top_ff == '0) begin
                  cur_bad_ff <= 1'b0;
                  state_ff   <= S_DONE;
               end else begin
                  state_ff <= S_HIST_WT;
               end
            end
            S_HIST_WT: state_ff <= S_JOIN_WR2;
            S_JOIN_WR2: begin
               cur_bad_ff <= h_rd;
               state_ff   <= S_DONE;
            end
            S_HIST_WR: begin
               h_top_ff   <= h_top_ff + 1'b1;
               cur_bad_ff <= bad_ff;
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               busy      <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // verdict after the transaction
   assign rsp_data.bipartite = (h_top_ff == '0) ? 1'b1 : !cur_bad_ff;
   assign rsp_data.status    = status_ff;

   `ASSERT_IMPL(a_hist_bound, clock, reset, 1'b1, h_top_ff <= (HIST_W+1)'(MAX_OPS))
   `ASSERT_IMPL(a_rb_bound, clock, reset, 1'b1, rb_top_ff <= (RB_W+1)'(RB_DEPTH))
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, state_ff == S_IDLE)
endmodule
`default_nettype wire

[tb/bipartite_check_with_undo_core_tb.sv]
// ----------------------------------------------------------------------------
// bipartite_check_with_undo_core_tb
// Self-checking bench for the bipartite check core with undo. Each
// transaction is mirrored in a local union-find model with a rollback stack,
// and every response is compared against it. Stimulus covers a short
// directed table, random add/undo traffic under several vertex counts, and
// a closing burst sent back to back with no idle gaps.
// ----------------------------------------------------------------------------
`default_nettype none
module bipartite_check_with_undo_core_tb;
   import bcu_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic [10:0] csr_vertex_count;

   bipartite_check_with_undo_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_we           (csr_we),
      .csr_vertex_count (csr_vertex_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow union-find store: two nodes per vertex, union by size, no
   // path compression, so every union can be reversed from the stack.
   // ---------------------------------------------------------------------
   int unsigned uf_parent [NODE_COUNT];
   int unsigned uf_size   [NODE_COUNT];
   bit          rb_made   [RB_DEPTH];
   int unsigned rb_root   [RB_DEPTH];
   int unsigned rb_child  [RB_DEPTH];
   int unsigned rb_top;
   bit          hist_bad  [MAX_OPS];
   int unsigned hist_top;
   int unsigned vcount;

   rsp_type pending_verdicts[$];
   int      errors;
   int      n_checked, n_nonbip, n_undo_empty, n_range, n_full;
   bit      sender_idle_en;

   function automatic int unsigned find_root(int unsigned n);
      while (uf_parent[n] != n) n = uf_parent[n];
      return n;
   endfunction

   function automatic void push_union(bit made, int unsigned r, int unsigned c);
      if (rb_top < RB_DEPTH) begin
         rb_made[rb_top]  = made;
         rb_root[rb_top]  = r;
         rb_child[rb_top] = c;
         rb_top++;
      end
   endfunction

   function automatic void join_sets(int unsigned p, int unsigned q);
      int unsigned x, y, t;
      x = find_root(p);
      y = find_root(q);
      if (x == y) begin
         push_union(1'b0, 0, 0);
         return;
      end
      if (uf_size[x] > uf_size[y]) begin
         t = x; x = y; y = t;
      end
      uf_parent[x] = y;
      uf_size[y] += uf_size[x];
      push_union(1'b1, y, x);
   endfunction

   function automatic void undo_union();
      if (rb_top == 0) return;
      rb_top--;
      if (rb_made[rb_top]) begin
         uf_size[rb_root[rb_top]] -= uf_size[rb_child[rb_top]];
         uf_parent[rb_child[rb_top]] = rb_child[rb_top];
      end
   endfunction

   function automatic bit graph_bipartite();
      return (hist_top == 0) ? 1'b1 : !hist_bad[hist_top-1];
   endfunction

   function automatic int unsigned vertex_limit();
      return (vcount < MAX_VERTICES) ? vcount : MAX_VERTICES;
   endfunction

   // Applies one transaction to the shadow state and returns the response.
   function automatic rsp_type verdict_after(req_type r);
      rsp_type     res;
      int unsigned a0, b0, lim;
      bit          bad;
      lim = vertex_limit();
      res.status = ST_OK;
      if (r.cmd == CMD_UNDO) begin
         if (hist_top == 0) res.status = ST_UNDO_EMPTY;
         else begin
            if (!hist_bad[hist_top-1]) begin
               undo_union();
               undo_union();
            end
            hist_top--;
         end
      end else if (r.vertex_a == 0 || r.vertex_b == 0 ||
                   r.vertex_a > lim || r.vertex_b > lim) begin
         res.status = ST_RANGE;
      end else if (hist_top >= MAX_OPS) begin
         res.status = ST_FULL;
      end else begin
         a0 = 2 * (r.vertex_a - 1);
         b0 = 2 * (r.vertex_b - 1);
         if (!graph_bipartite()) bad = 1'b1;
         else if (find_root(a0) == find_root(b0) ||
                  find_root(a0+1) == find_root(b0+1)) bad = 1'b1;
         else begin
            join_sets(a0, b0 + 1);
            join_sets(a0 + 1, b0);
            bad = 1'b0;
         end
         hist_bad[hist_top] = bad;
         hist_top++;
      end
      res.bipartite = graph_bipartite();
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Response checker: one strobe per transaction, in order, no back-pressure.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = pending_verdicts.pop_front();
            n_checked++;
            if (rsp_data.bipartite !== exp_rsp.bipartite) begin
               $display("%0t: bipartite mismatch expected %0b actual %0b",
                        $time, exp_rsp.bipartite, rsp_data.bipartite);
               errors++;
            end
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status mismatch expected %0d actual %0d",
                        $time, exp_rsp.status, rsp_data.status);
               errors++;
            end
            if (exp_rsp.bipartite == 1'b0) n_nonbip++;
            case (exp_rsp.status)
               ST_UNDO_EMPTY: n_undo_empty++;
               ST_RANGE:      n_range++;
               ST_FULL:       n_full++;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender. start stays high across back-to-back transactions; the data
   // changes with a single NBA at the edge that took the previous one.
   // ---------------------------------------------------------------------
   task automatic issue(req_type r, bit has_typed, rsp_type typed);
      rsp_type pred;
      if (start && sender_idle_en && ($urandom_range(0, 3) == 0)) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      // transaction taken at this edge
      pred = verdict_after(r);
      if (has_typed && pred !== typed) begin
         $display("%0t: table entry disagrees with model expected %p model %p",
                  $time, typed, pred);
         errors++;
      end
      pending_verdicts.push_back(has_typed ? typed : pred);
   endtask

   // Waits until every response is in and the core has settled.
   task automatic drain();
      if (start) start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_vertex_count(int unsigned v);
      drain();
      csr_we           <= 1'b1;
      csr_vertex_count <= v[10:0];
      @(posedge clock);
      csr_we <= 1'b0;
      vcount = v & 11'h7ff;
   endtask

   // Mostly in-range endpoints from a small window so cycles close often;
   // the rest is full-width noise that also hits zero and out-of-range.
   function automatic logic [10:0] pick_vertex(int unsigned window);
      int unsigned lim;
      lim = vertex_limit();
      if (lim == 0 || $urandom_range(0, 99) < 8) return 11'($urandom_range(0, 2047));
      if (window > lim) window = lim;
      if ($urandom_range(0, 9) == 0) return 11'($urandom_range(1, lim));
      return 11'($urandom_range(1, window));
   endfunction

   task automatic random_traffic(int count, int unsigned window);
      req_type r;
      rsp_type none;
      none = '0;
      for (int i = 0; i < count; i++) begin
         r.cmd      = ($urandom_range(0, 99) < 35) ? CMD_UNDO : CMD_ADD;
         r.vertex_a = pick_vertex(window);
         r.vertex_b = pick_vertex(window);
         issue(r, 1'b0, none);
      end
   endtask

   // Directed table: expected values typed only where obvious.
   typedef struct {
      logic        cmd;
      int unsigned va, vb;
      bit          typed;
      logic        bip;
      logic [1:0]  st;
   } dir_row_type;

   dir_row_type dir_rows[] = '{
      '{CMD_UNDO, 0,    0,    1, 1'b1, ST_UNDO_EMPTY}, // undo, nothing held
      '{CMD_ADD,  0,    5,    1, 1'b1, ST_RANGE},      // vertex zero
      '{CMD_ADD,  5,    2047, 1, 1'b1, ST_RANGE},      // all-ones vertex
      '{CMD_ADD,  1025, 1,    1, 1'b1, ST_RANGE},      // just above max
      '{CMD_ADD,  1,    1,    1, 1'b0, ST_OK},         // self loop
      '{CMD_ADD,  1024, 2,    1, 1'b0, ST_OK},         // inherits the mark
      '{CMD_UNDO, 0,    0,    1, 1'b0, ST_OK},
      '{CMD_UNDO, 2047, 2047, 1, 1'b1, ST_OK},         // history empty again
      '{CMD_ADD,  1,    1024, 1, 1'b1, ST_OK},
      '{CMD_ADD,  1024, 2,    0, 1'b0, 2'd0},
      '{CMD_ADD,  2,    1,    0, 1'b0, 2'd0},          // closes odd cycle
      '{CMD_ADD,  3,    4,    0, 1'b0, 2'd0},
      '{CMD_UNDO, 0,    0,    0, 1'b0, 2'd0},
      '{CMD_UNDO, 0,    0,    0, 1'b0, 2'd0},
      '{CMD_ADD,  2,    3,    0, 1'b0, 2'd0},
      '{CMD_ADD,  3,    1,    0, 1'b0, 2'd0},          // even cycle stays ok
      '{CMD_ADD,  1024, 1024, 0, 1'b0, 2'd0},
      '{CMD_UNDO, 0,    0,    0, 1'b0, 2'd0},
      '{CMD_UNDO, 0,    0,    0, 1'b0, 2'd0},
      '{CMD_UNDO, 0,    0,    0, 1'b0, 2'd0},
      '{CMD_UNDO, 0,    0,    0, 1'b0, 2'd0},
      '{CMD_UNDO, 0,    0,    1, 1'b1, ST_OK}          // last add popped
   };

   initial begin
      req_type r;
      rsp_type typed;
      reset            = 1'b1;
      start            = 1'b0;
      req_data         = '0;
      csr_we           = 1'b0;
      csr_vertex_count = '0;
      errors = 0; n_checked = 0; n_nonbip = 0;
      n_undo_empty = 0; n_range = 0; n_full = 0;
      sender_idle_en = 1'b1;
      for (int i = 0; i < NODE_COUNT; i++) begin
         uf_parent[i] = i;
         uf_size[i]   = 1;
      end
      rb_top = 0; hist_top = 0; vcount = 1024;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // clearing pass after reset keeps busy high
      @(posedge clock);
      while (busy) @(posedge clock);

      foreach (dir_rows[i]) begin
         r.cmd      = dir_rows[i].cmd;
         r.vertex_a = dir_rows[i].va[10:0];
         r.vertex_b = dir_rows[i].vb[10:0];
         typed.bipartite = dir_rows[i].bip;
         typed.status    = dir_rows[i].st;
         issue(r, dir_rows[i].typed, typed);
      end

      // Random phases over a spread of vertex counts, extremes included.
      random_traffic(250, 10);
      drain();                       // hold the sender until all responses land
      random_traffic(100, 1024);
      write_vertex_count(2047);      // above the max clamps to 1024
      random_traffic(150, 16);
      write_vertex_count(1);         // only self loops are legal
      random_traffic(60, 1);
      write_vertex_count(0);         // every add out of range
      random_traffic(40, 4);
      write_vertex_count(7);
      random_traffic(200, 7);
      write_vertex_count(300);
      random_traffic(200, 24);
      write_vertex_count(1024);

      // Final part, no idling: transactions back to back.
      sender_idle_en = 1'b0;
      random_traffic(30, 12);

      drain();
      $display("Checked %0d responses: %0d non-bipartite, %0d empty undos,",
               n_checked, n_nonbip, n_undo_empty);
      $display("%0d out-of-range adds, %0d adds refused on a full history.",
               n_range, n_full);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("bipartite_check_with_undo_core verification clean");
      end else begin
         $display("bipartite_check_with_undo_core verification failed");
      end
      $finish;
   end

   // Watchdog, sized well above the slowest legal run.
   initial begin
      #60_000_000;
      $display("bipartite_check_with_undo_core verification failed");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/bcu_pkg.sv
rtl/bcu_ram.sv
rtl/bipartite_check_with_undo_core.sv
tb/bipartite_check_with_undo_core_tb.sv
